// ===== rtl/error_diffusion_dither_4bit_core_assert.svh =====
// Assertion macros for the 4-bit error diffusion dither core.
// Used by the top level; needs clk and arst_n in the including scope.
`ifndef ERROR_DIFFUSION_DITHER_4BIT_CORE_ASSERT_SVH
`define ERROR_DIFFUSION_DITHER_4BIT_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define ED4_ASSERT_SAME(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("ed4 assertion failed");
`define ED4_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("ed4 assertion failed");
`else
`define ED4_ASSERT_SAME(lbl, a, b)
`define ED4_ASSERT_NEXT(lbl, a, b)
`endif

`endif

// ===== rtl/ed4_pkg.sv =====
// Shared constants and types for the 4-bit error diffusion dither core.
// No dependencies.
`default_nettype none

package ed4_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int CNT_W     = $clog2(MAX_WIDTH + 1);
	localparam int WCFG_W    = 11;
	localparam int HCFG_W    = 16;
	localparam int WCMP_W    = (CNT_W > WCFG_W) ? CNT_W : WCFG_W;
	localparam int ERR_W     = 3;
	localparam int CFG_DW    = 16;

	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	typedef struct packed {
		logic             we;
		logic [COL_W-1:0] addr;
		logic [ERR_W-1:0] data;
	} rowmem_wr_t;

endpackage

`default_nettype wire

// ===== rtl/error_diffusion_dither_4bit_core.sv =====
// Top level of the 4-bit error diffusion dither core.
// Depends on ed4_pkg, ed4_row_mem and error_diffusion_dither_4bit_core_assert.svh.
//
// Takes one 8-bit gray pixel per clock in raster order while in_stall is low and
// returns one dithered pixel per input, through an input register and then the
// result register, when the output is not stalled. The sustained rate of one pixel
// per cycle is set by the right-carry loop, which runs from the carry register
// through the error adder back into the carry register. After reset the block
// clears its row error store, one entry per cycle, over all MAX_WIDTH (1024)
// entries; it stalls its input meanwhile while still taking configuration writes.
`default_nettype none

module error_diffusion_dither_4bit_core
	import ed4_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [CFG_DW-1:0] cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [7:0]        pixel_in,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [7:0]        dithered_value,
	output logic                   frame_end
);

`include "error_diffusion_dither_4bit_core_assert.svh"

	logic [WCFG_W-1:0] image_width_q;
	logic [HCFG_W-1:0] image_height_q;
	logic [COL_W-1:0]  col_q;
	logic [HCFG_W-1:0] row_q;
	logic [3:0]        rc_q;
	logic              clearing_q;
	logic [COL_W-1:0]  clr_cnt_q;

	logic              valid_s1;
	logic [7:0]        pixel_s1;
	logic [COL_W-1:0]  col_s1;
	logic              first_row_s1;
	logic              last_col_s1;
	logic              last_row_s1;

	logic              pend_valid_q;
	logic [COL_W-1:0]  pend_addr_q;
	logic [ERR_W-1:0]  pend_data_q;
	logic              lw_valid_q;
	logic [COL_W-1:0]  lw_addr_q;
	logic [ERR_W-1:0]  lw_data_q;

	logic              in_accept;
	logic              fire_s1;
	logic              w1;
	logic [WCMP_W-1:0] weff;
	logic [WCMP_W-1:0] wcfg_ext;
	logic [HCFG_W:0]   heff;
	logic              last_col;
	logic              last_row;
	logic [COL_W-1:0]  rd_addr0;
	logic [COL_W-1:0]  rd_addr1;
	logic [ERR_W-1:0]  rd_data0;
	logic [ERR_W-1:0]  rd_data1;
	logic [ERR_W-1:0]  val0;
	logic [ERR_W-1:0]  val1;
	logic [ERR_W-1:0]  below;
	logic [8:0]        sum9;
	logic [7:0]        sum;
	logic [3:0]        err;
	logic [6:0]        err5_full;
	logic [5:0]        err3_full;
	logic [6:0]        err7_full;
	logic [ERR_W-1:0]  err5;
	logic [1:0]        err3;
	logic [ERR_W-1:0]  err7;
	rowmem_wr_t        wr;

	assign in_stall  = clearing_q || (valid_s1 && !fire_s1);
	assign in_accept = in_valid && !in_stall;
	assign fire_s1   = valid_s1 && (!out_valid || !out_stall);

	assign wcfg_ext = WCMP_W'(image_width_q);
	assign weff = (image_width_q == '0) ? WCMP_W'(1) :
		(wcfg_ext > WCMP_W'(MAX_WIDTH)) ? WCMP_W'(MAX_WIDTH) : wcfg_ext;
	assign heff = (image_height_q == '0) ? (HCFG_W+1)'(1) : {1'b0, image_height_q};
	assign last_col = (WCMP_W'(col_q) + WCMP_W'(1)) >= weff;
	assign last_row = ({1'b0, row_q} + (HCFG_W+1)'(1)) >= heff;

	assign rd_addr0 = in_accept ? col_q : col_s1;
	assign rd_addr1 = rd_addr0 - COL_W'(1);

	ed4_row_mem u_row_mem (
		.clk      (clk),
		.wr       (wr),
		.rd_addr0 (rd_addr0),
		.rd_addr1 (rd_addr1),
		.rd_data0 (rd_data0),
		.rd_data1 (rd_data1)
	);

	always_comb begin
		val0 = rd_data0;
		if (lw_valid_q && lw_addr_q == col_s1) val0 = lw_data_q;
		if (pend_valid_q && pend_addr_q == col_s1) val0 = pend_data_q;
		val1 = rd_data1;
		if (lw_valid_q && lw_addr_q == col_s1 - COL_W'(1)) val1 = lw_data_q;
		if (pend_valid_q && pend_addr_q == col_s1 - COL_W'(1)) val1 = pend_data_q;
	end

	assign below     = first_row_s1 ? '0 : val0;
	assign sum9      = {1'b0, pixel_s1} + 9'(rc_q) + 9'(below);
	assign sum       = sum9[8] ? 8'hFF : sum9[7:0];
	assign err       = sum[3:0];
	assign err5_full = 7'(err) * 7'd5;
	assign err3_full = 6'(err) * 6'd3;
	assign err7_full = 7'(err) * 7'd7;
	assign err5      = err5_full[6:4];
	assign err3      = err3_full[5:4];
	assign err7      = err7_full[6:4];

	assign w1 = fire_s1 && !last_row_s1 && (col_s1 != '0);

	always_comb begin
		wr = '0;
		if (clearing_q) begin
			wr.we   = 1'b1;
			wr.addr = clr_cnt_q;
		end else if (w1) begin
			wr.we   = 1'b1;
			wr.addr = col_s1 - COL_W'(1);
			wr.data = val1 + ERR_W'(err3);
		end else if (pend_valid_q) begin
			wr.we   = 1'b1;
			wr.addr = pend_addr_q;
			wr.data = pend_data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WCFG_W'(1024);
			image_height_q <= HCFG_W'(1024);
			col_q          <= '0;
			row_q          <= '0;
			rc_q           <= '0;
			clearing_q     <= 1'b1;
			clr_cnt_q      <= '0;
			valid_s1       <= 1'b0;
			out_valid      <= 1'b0;
			pend_valid_q   <= 1'b0;
			lw_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[WCFG_W-1:0];
					REG_IMAGE_HEIGHT: image_height_q <= cfg_data[HCFG_W-1:0];
					default: ;
				endcase
			end
			if (clearing_q) begin
				clr_cnt_q <= clr_cnt_q + COL_W'(1);
				if (clr_cnt_q == COL_W'(MAX_WIDTH - 1)) clearing_q <= 1'b0;
			end
			if (in_accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + HCFG_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
				valid_s1 <= 1'b1;
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
			end
			if (fire_s1) begin
				out_valid <= 1'b1;
				if (last_col_s1) rc_q <= '0;
				else rc_q <= last_row_s1 ? err : 4'(err7);
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			if (fire_s1 && !last_row_s1) begin
				pend_valid_q <= 1'b1;
			end else if (!clearing_q && !w1) begin
				pend_valid_q <= 1'b0;
			end
			lw_valid_q <= wr.we;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			pixel_s1     <= pixel_in;
			col_s1       <= col_q;
			first_row_s1 <= (row_q == '0);
			last_col_s1  <= last_col;
			last_row_s1  <= last_row;
		end
		if (fire_s1) begin
			dithered_value <= {sum[7:4], 4'b0000};
			frame_end      <= last_col_s1 && last_row_s1;
		end
		if (fire_s1 && !last_row_s1) begin
			pend_addr_q <= col_s1;
			pend_data_q <= err5;
		end
		lw_addr_q <= wr.addr;
		lw_data_q <= wr.data;
	end

	`ED4_ASSERT_SAME(a_pend_matches_left, w1 && pend_valid_q,
		pend_addr_q == col_s1 - COL_W'(1))
	`ED4_ASSERT_SAME(a_no_accept_in_clear, clearing_q, !in_accept && !valid_s1)
	`ED4_ASSERT_NEXT(a_last_row_flushes, fire_s1 && last_row_s1, !pend_valid_q)
	`ED4_ASSERT_NEXT(a_fire_shows_result, fire_s1, out_valid)

endmodule

`default_nettype wire

// ===== rtl/ed4_row_mem.sv =====
// Row error store: one write port, two registered read ports.
// Depends on ed4_pkg.
`default_nettype none

module ed4_row_mem
	import ed4_pkg::*;
(
	input  wire logic             clk,
	input  wire rowmem_wr_t       wr,
	input  wire logic [COL_W-1:0] rd_addr0,
	input  wire logic [COL_W-1:0] rd_addr1,
	output logic      [ERR_W-1:0] rd_data0,
	output logic      [ERR_W-1:0] rd_data1
);

	logic [ERR_W-1:0] mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data0 <= mem[rd_addr0];
		rd_data1 <= mem[rd_addr1];
	end

endmodule

`default_nettype wire
